@@ sv/gbag_pkg.sv @@
// ----------------------------------------------------------------------------
// gbag_pkg
// Shared types and constants of the glyph blit address generator.
// ----------------------------------------------------------------------------
package gbag_pkg;

    // defaults of the top level parameters
    localparam int FRAME_ADDR_BITS_DEF = 22;
    localparam int GLYPH_WIDTH_DEF     = 5;
    localparam int GLYPH_HEIGHT_DEF    = 7;
    localparam int CHAR_ADVANCE_DEF    = 6;
    localparam int LINE_PITCH_DEF      = 8;
    localparam int QUEUE_DEPTH_DEF     = 2;

    // fixed field widths
    localparam int CFG_W     = 13;
    localparam int ROW_W     = 13;
    localparam int COORD_W   = 12;
    localparam int CODE_W    = 8;
    localparam int SRC_W     = 15;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W = 32;
    localparam int IN_USER_W = 2;

    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_WIDTH  = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST = 13'd640;
    localparam logic [CFG_W-1:0] FONT_WIDTH_RST  = 13'd1280;

    // input tdata, start_col in the lowest bits
    typedef struct packed {
        logic [CODE_W-1:0]  char_code;
        logic [COORD_W-1:0] start_row;
        logic [COORD_W-1:0] start_col;
    } t_in_data;

    // input tuser, first_of_string in bit 0
    typedef struct packed {
        logic next_is_newline;
        logic first_of_string;
    } t_in_user;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MUL   = 4'b0010,
        ST_BASE  = 4'b0100,
        ST_BREAK = 4'b1000
    } t_front_state;

endpackage

@@ sv/gbag_queue.sv @@
// ----------------------------------------------------------------------------
// gbag_queue
// Short FIFO of glyph jobs between the front end and the pixel engine.
// ----------------------------------------------------------------------------
module gbag_queue #(
    parameter int DATA_W = 37,
    parameter int DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output logic [DATA_W-1:0] o_pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              w_push, w_pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ sv/gbag_front.sv @@
// ----------------------------------------------------------------------------
// gbag_front
// Takes characters, keeps the text cursor and line state, and queues one
// glyph job per printable character.
// ----------------------------------------------------------------------------
module gbag_front #(
    parameter int FRAME_ADDR_BITS = 22,
    parameter int GLYPH_WIDTH     = 5,
    parameter int CHAR_ADVANCE    = 6,
    parameter int LINE_PITCH      = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [gbag_pkg::CFG_W-1:0] i_frame_width,
    input  logic                       i_item_valid,
    output logic                       o_item_ready,
    input  gbag_pkg::t_in_data         i_item_data,
    input  gbag_pkg::t_in_user         i_item_user,
    output logic                       o_push_valid,
    input  logic                       i_push_ready,
    output logic [gbag_pkg::SRC_W-1:0] o_push_src,
    output logic [FRAME_ADDR_BITS-1:0] o_push_dst
);
    import gbag_pkg::*;

    localparam int A       = FRAME_ADDR_BITS;
    localparam int PROD_W  = ROW_W + CFG_W;
    localparam int PITCH_W = 6;
    localparam logic [A-1:0]       ADV_C   = A'(CHAR_ADVANCE);
    localparam logic [CFG_W-1:0]   GW_C    = CFG_W'(GLYPH_WIDTH);
    localparam logic [SRC_W-1:0]   GW_SRC  = SRC_W'(GLYPH_WIDTH);
    localparam logic [PITCH_W-1:0] PITCH_C = PITCH_W'(LINE_PITCH);
    localparam logic [ROW_W-1:0]   PITCH_R = ROW_W'(LINE_PITCH);

    t_front_state r_state, n_state;

    // input holding register
    logic     r_slot_valid, n_slot_valid;
    t_in_data r_slot_data;
    t_in_user r_slot_user;

    // character being worked on
    logic [COORD_W-1:0] r_scol, r_srow;
    logic [CODE_W-1:0]  r_code;
    logic               r_first, r_next_nl;
    logic [A-1:0]       r_prod;

    // text state
    logic [A-1:0]     r_cursor, n_cursor;
    logic [A-1:0]     r_line_start, n_line_start;
    logic [ROW_W-1:0] r_line_row, n_line_row;

    logic [ROW_W-1:0]         w_row_sel;
    logic [PROD_W-1:0]        w_mul;
    logic [CFG_W+PITCH_W-1:0] w_pitch_prod;
    logic [A-1:0]             w_base, w_col, w_limit, w_next_line;
    logic                     w_is_nl, w_take;

    assign o_item_ready = !r_slot_valid;
    assign w_take       = r_slot_valid && (r_state == ST_IDLE);

    assign w_row_sel    = r_first ? {1'b0, r_srow} : r_line_row;
    assign w_mul        = {{ROW_W{1'b0}}, i_frame_width} * {{CFG_W{1'b0}}, w_row_sel};
    assign w_pitch_prod = {{PITCH_W{1'b0}}, i_frame_width}
                        * {{CFG_W{1'b0}}, PITCH_C};
    assign w_is_nl      = (r_code == NEWLINE_CODE);
    assign w_base       = r_first ? (r_prod + A'(r_scol)) : r_cursor;
    assign w_col        = r_cursor - r_prod;
    assign w_limit      = (i_frame_width > GW_C) ? A'(i_frame_width - GW_C) : '0;
    assign w_next_line  = r_line_start + A'(w_pitch_prod);

    assign o_push_valid = (r_state == ST_BASE) && !w_is_nl;
    assign o_push_src   = SRC_W'(r_code) * GW_SRC;
    assign o_push_dst   = w_base;

    always_comb begin
        n_state      = r_state;
        n_slot_valid = r_slot_valid;
        n_cursor     = r_cursor;
        n_line_start = r_line_start;
        n_line_row   = r_line_row;
        if (i_item_valid && o_item_ready) begin
            n_slot_valid = 1'b1;
        end else if (w_take) begin
            n_slot_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (r_slot_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_first) begin
                    n_line_row = {1'b0, r_srow};
                end
                n_state = ST_BASE;
            end
            ST_BASE: begin
                if (w_is_nl || i_push_ready) begin
                    n_cursor = w_is_nl ? w_base : w_base + ADV_C;
                    if (r_first) begin
                        n_line_start = w_base;
                    end
                    n_state = ST_BREAK;
                end
            end
            ST_BREAK: begin
                // r_prod holds line_row * frame_width of the current line
                if (w_col >= w_limit || r_next_nl) begin
                    n_line_start = w_next_line;
                    n_cursor     = w_next_line;
                    n_line_row   = r_line_row + PITCH_R;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_slot_valid <= 1'b0;
            r_cursor     <= '0;
            r_line_start <= '0;
            r_line_row   <= '0;
        end else begin
            r_state      <= n_state;
            r_slot_valid <= n_slot_valid;
            r_cursor     <= n_cursor;
            r_line_start <= n_line_start;
            r_line_row   <= n_line_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item_valid && o_item_ready) begin
            r_slot_data <= i_item_data;
            r_slot_user <= i_item_user;
        end
        if (w_take) begin
            r_scol    <= r_slot_data.start_col;
            r_srow    <= r_slot_data.start_row;
            r_code    <= r_slot_data.char_code;
            r_first   <= r_slot_user.first_of_string;
            r_next_nl <= r_slot_user.next_is_newline;
        end
        if (r_state == ST_MUL) begin
            r_prod <= A'(w_mul);
        end
    end

endmodule

@@ sv/gbag_back.sv @@
// ----------------------------------------------------------------------------
// gbag_back
// Pixel engine: walks one glyph row by row and sends a source and
// destination index pair per cycle through an output register unless stalled.
// ----------------------------------------------------------------------------
module gbag_back #(
    parameter int FRAME_ADDR_BITS = 22,
    parameter int GLYPH_WIDTH     = 5,
    parameter int GLYPH_HEIGHT    = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [gbag_pkg::CFG_W-1:0] i_frame_width,
    input  logic [gbag_pkg::CFG_W-1:0] i_font_width,
    input  logic                       i_pop_valid,
    output logic                       o_pop_ready,
    input  logic [gbag_pkg::SRC_W-1:0] i_pop_src,
    input  logic [FRAME_ADDR_BITS-1:0] i_pop_dst,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [gbag_pkg::SRC_W-1:0] o_src,
    output logic [FRAME_ADDR_BITS-1:0] o_dst,
    output logic                       o_last
);
    import gbag_pkg::*;

    localparam int A  = FRAME_ADDR_BITS;
    localparam int CW = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
    localparam int RW = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
    localparam logic [CW-1:0] COL_LAST = CW'(GLYPH_WIDTH - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(GLYPH_HEIGHT - 1);

    logic             r_active, n_active;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [SRC_W-1:0] r_row_src;
    logic [A-1:0]     r_row_dst;
    logic             r_out_valid, n_out_valid;
    logic [SRC_W-1:0] r_out_src;
    logic [A-1:0]     r_out_dst;
    logic             r_out_last;

    logic w_advance, w_col_last, w_pix_last, w_pop;

    assign w_advance   = r_active && (!r_out_valid || i_ready);
    assign w_col_last  = (r_col == COL_LAST);
    assign w_pix_last  = w_col_last && (r_row == ROW_LAST);
    assign o_pop_ready = !r_active || (w_advance && w_pix_last);
    assign w_pop       = i_pop_valid && o_pop_ready;

    assign o_valid = r_out_valid;
    assign o_src   = r_out_src;
    assign o_dst   = r_out_dst;
    assign o_last  = r_out_last;

    always_comb begin
        n_active    = r_active;
        n_out_valid = r_out_valid;
        if (w_pop) begin
            n_active = 1'b1;
        end else if (w_advance && w_pix_last) begin
            n_active = 1'b0;
        end
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_src  <= r_row_src + SRC_W'(r_col);
            r_out_dst  <= r_row_dst + A'(r_col);
            r_out_last <= w_pix_last;
        end
        if (w_pop) begin
            r_col     <= '0;
            r_row     <= '0;
            r_row_src <= i_pop_src;
            r_row_dst <= i_pop_dst;
        end else if (w_advance) begin
            if (w_col_last) begin
                // next glyph row: step both bases by one image row
                r_col     <= '0;
                r_row     <= r_row + 1'b1;
                r_row_src <= r_row_src + SRC_W'(i_font_width);
                r_row_dst <= r_row_dst + A'(i_frame_width);
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

endmodule

@@ sv/glyph_blit_address_generator_unit.sv @@
// ----------------------------------------------------------------------------
// glyph_blit_address_generator_unit
// Turns a stream of text characters into font strip and frame buffer pixel
// index pairs for a bitmap font blit.
// ----------------------------------------------------------------------------
// Each printable character yields GLYPH_WIDTH*GLYPH_HEIGHT index pairs (35 for
// the 5x7 font), one per cycle from the pixel engine while the output is not
// stalled; for a steady text stream the pixel engine is the limit. A newline
// yields no pairs and is handled by the front end alone. The front end
// registers each character, computes the start position and the line-break
// test through its idle, multiply, base and break states (the multiply state
// for the row times width product), and queues glyph jobs two deep, so the
// next characters are taken while a glyph is still being sent. The user must
// write configuration through the cfg port only while no character is in
// flight; the block itself does not enforce it.
module glyph_blit_address_generator_unit #(
    parameter int FRAME_ADDR_BITS = gbag_pkg::FRAME_ADDR_BITS_DEF,
    parameter int GLYPH_WIDTH     = gbag_pkg::GLYPH_WIDTH_DEF,
    parameter int GLYPH_HEIGHT    = gbag_pkg::GLYPH_HEIGHT_DEF,
    parameter int CHAR_ADVANCE    = gbag_pkg::CHAR_ADVANCE_DEF,
    parameter int LINE_PITCH      = gbag_pkg::LINE_PITCH_DEF,
    parameter int QUEUE_DEPTH     = gbag_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // start_col[11:0], start_row[23:12], char_code[31:24]
    input  logic [gbag_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // first_of_string[0], next_is_newline[1]
    input  logic [gbag_pkg::IN_USER_W-1:0]     i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // src_index[14:0], dst_index[FRAME_ADDR_BITS+14:15], zero fill above
    output logic [((gbag_pkg::SRC_W+FRAME_ADDR_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    output logic                               o_m_axis_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gbag_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gbag_pkg::CFG_W-1:0]         i_cfg_data
);
    import gbag_pkg::*;

    localparam int A     = FRAME_ADDR_BITS;
    localparam int OUT_W = ((SRC_W + FRAME_ADDR_BITS + 7) / 8) * 8;
    localparam int JOB_W = SRC_W + A;

    logic [CFG_W-1:0] r_frame_width, r_font_width;

    logic             w_push_valid, w_push_ready;
    logic [SRC_W-1:0] w_push_src;
    logic [A-1:0]     w_push_dst;
    logic             w_pop_valid, w_pop_ready;
    logic [JOB_W-1:0] w_pop_data;
    logic [SRC_W-1:0] w_out_src;
    logic [A-1:0]     w_out_dst;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= FRAME_WIDTH_RST;
            r_font_width  <= FONT_WIDTH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH: r_frame_width <= i_cfg_data;
                CFG_FONT_WIDTH:  r_font_width  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    gbag_front #(
        .FRAME_ADDR_BITS (FRAME_ADDR_BITS),
        .GLYPH_WIDTH     (GLYPH_WIDTH),
        .CHAR_ADVANCE    (CHAR_ADVANCE),
        .LINE_PITCH      (LINE_PITCH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_width (r_frame_width),
        .i_item_valid  (i_s_axis_tvalid),
        .o_item_ready  (o_s_axis_tready),
        .i_item_data   (t_in_data'(i_s_axis_tdata)),
        .i_item_user   (t_in_user'(i_s_axis_tuser)),
        .o_push_valid  (w_push_valid),
        .i_push_ready  (w_push_ready),
        .o_push_src    (w_push_src),
        .o_push_dst    (w_push_dst)
    );

    gbag_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  ({w_push_dst, w_push_src}),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    gbag_back #(
        .FRAME_ADDR_BITS (FRAME_ADDR_BITS),
        .GLYPH_WIDTH     (GLYPH_WIDTH),
        .GLYPH_HEIGHT    (GLYPH_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_width (r_frame_width),
        .i_font_width  (r_font_width),
        .i_pop_valid   (w_pop_valid),
        .o_pop_ready   (w_pop_ready),
        .i_pop_src     (w_pop_data[SRC_W-1:0]),
        .i_pop_dst     (w_pop_data[JOB_W-1:SRC_W]),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_src         (w_out_src),
        .o_dst         (w_out_dst),
        .o_last        (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = OUT_W'({w_out_dst, w_out_src});

endmodule

@@ sv/gbag_checker.sv @@
// ----------------------------------------------------------------------------
// gbag_checker
// Port-level checks of the glyph blit address generator, bound to the top.
// ----------------------------------------------------------------------------
module gbag_checker #(
    parameter int FRAME_ADDR_BITS = gbag_pkg::FRAME_ADDR_BITS_DEF
) (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_s_axis_tvalid,
    input logic                                   o_s_axis_tready,
    input logic                                   o_m_axis_tvalid,
    input logic                                   i_m_axis_tready,
    // src_index[14:0], dst_index above it, zero fill
    input logic [((gbag_pkg::SRC_W+FRAME_ADDR_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    input logic                                   o_m_axis_tlast
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("result beat changed while stalled");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // an accepted character occupies the input register and holds tready low after the transfer
    a_in_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input register not held after a transaction");

    // inside a glyph the next pixel follows without a gap
    a_glyph_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=> o_m_axis_tvalid)
        else $error("gap inside a glyph");

endmodule

bind glyph_blit_address_generator_unit gbag_checker #(
    .FRAME_ADDR_BITS (FRAME_ADDR_BITS)
) u_gbag_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
